>>> hdl/ic_pkg.sv
// Shared constants and the token type that travels along the compare row.
package ic_pkg;

	localparam int MAX_LEN    = 256;
	localparam int VALUE_BITS = 32;
	localparam int DATA_W     = 32;
	localparam int TOTAL_W    = 15;
	localparam int CNT_W      = $clog2(MAX_LEN);
	localparam int OUT_DATA_W = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// One element on its way down the row, with the count gathered so far.
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic                  stored;
		logic [VALUE_BITS-1:0] key;
		logic [CNT_W-1:0]      cnt;
	} token_t;

endpackage

>>> hdl/inversion_counter.sv
// Top level: inversion counter built as a row of compare cells.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: value (32, signed); tlast: last element
//  m_axis   | out       | tdata: inversions (15, zero-padded to 16); tuser: overflow
//
// One element is taken per cycle while the row is not stalled; each element walks the MAX_LEN cells,
// one cell a cycle unless stalled, and the tail registers the result once the element marked last leaves the row.
// Reset clears every cell's occupied bit, the running total and the overflow flag.
// The row stalls (tready low) only while a finished run reaches the tail and the
// previous result still waits on m_axis.
module inversion_counter import ic_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,  // [31:0] value
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [14:0] inversions, [15] zero
	output logic                  m_axis_tuser   // [0] overflow
);

	token_t             tok [MAX_LEN+1];
	logic               en;
	logic [TOTAL_W-1:0] inversions;

	always_comb begin
		tok[0].valid  = s_axis_tvalid && en;
		tok[0].last   = s_axis_tlast;
		tok[0].stored = 1'b0;
		tok[0].key    = s_axis_tdata[VALUE_BITS-1:0];
		tok[0].cnt    = '0;
	end

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		ic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	ic_tail u_tail (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok            (tok[MAX_LEN]),
		.en             (en),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_inversions (inversions),
		.out_overflow   (m_axis_tuser)
	);

	assign s_axis_tready = en;
	assign m_axis_tdata  = OUT_DATA_W'(inversions);

endmodule

>>> hdl/ic_cell.sv
// One compare cell: holds one stored element and counts passing tokens against it.
module ic_cell import ic_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  token_t tok_in,
	output token_t tok_out
);

	logic                  occ_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  valid_q;
	logic                  last_q;
	logic                  stored_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  gt;
	logic                  place;
	token_t                tok_nxt;

	assign gt    = tok_in.valid && occ_q && ($signed(val_q) > $signed(tok_in.key));
	assign place = tok_in.valid && !occ_q && !tok_in.stored;

	always_comb begin
		tok_nxt        = tok_in;
		tok_nxt.cnt    = tok_in.cnt + CNT_W'(gt);
		tok_nxt.stored = tok_in.stored | place;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tok_nxt.valid;
			// the last element of a run empties the cell behind it
			if (tok_in.valid && tok_in.last) begin
				occ_q <= 1'b0;
			end else if (place) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q   <= tok_nxt.last;
			stored_q <= tok_nxt.stored;
			key_q    <= tok_nxt.key;
			cnt_q    <= tok_nxt.cnt;
			if (place && !tok_in.last) begin
				val_q <= tok_in.key;
			end
		end
	end

	always_comb begin
		tok_out.valid  = valid_q;
		tok_out.last   = last_q;
		tok_out.stored = stored_q;
		tok_out.key    = key_q;
		tok_out.cnt    = cnt_q;
	end

endmodule

>>> hdl/ic_tail.sv
// End of the row: accumulates counts, flags dropped elements and holds the result.
module ic_tail import ic_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  token_t                tok,
	output logic                  en,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TOTAL_W-1:0]    out_inversions,
	output logic                  out_overflow
);

	logic [TOTAL_W-1:0] total_q;
	logic               ovf_q;
	logic               out_valid_q;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_nxt;
	logic               ovf_nxt;

	// hold the row only when a finished run meets a result not yet taken
	assign en = !(out_valid_q && !out_ready && tok.valid && tok.last);

	always_comb begin
		sum       = {1'b0, total_q} + (TOTAL_W + 1)'(tok.stored ? tok.cnt : '0);
		total_nxt = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
		ovf_nxt   = ovf_q | !tok.stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (en && tok.valid) begin
				if (tok.last) begin
					total_q     <= '0;
					ovf_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					total_q <= total_nxt;
					ovf_q   <= ovf_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tok.valid && tok.last) begin
			out_inversions <= total_nxt;
			out_overflow   <= ovf_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/ic_checker.sv
// Port-level checks for the inversion counter, bound to the top level.
module ic_checker import ic_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [DATA_W-1:0]     s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser
);

	// a result waiting on the output holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// input back-pressure only comes from a blocked result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked result");

	// padding bit above the count stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1] == 1'b0)
		else $error("padding bit set");

	// a full run of MAX_LEN elements has at most MAX_LEN*(MAX_LEN-1)/2 inversions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[TOTAL_W-1:0]) <= 32'(MAX_LEN * (MAX_LEN - 1) / 2))
		else $error("inversion count out of range");

endmodule

bind inversion_counter ic_checker u_ic_checker (.*);

>>> bench/inversion_counter_tb.sv
// Self-checking bench for the inversion counter: random and directed runs against a software count.
`timescale 1ns / 1ps

module inversion_counter_tb;
	import ic_pkg::*;

	localparam int SAT_TOTAL   = 2**TOTAL_W - 1;
	// Worst quiet stretch: the long hold-off plus one trip down the row, taken many times over.
	localparam int STUCK_LIMIT = 20000;
	localparam int HOLD_OFF    = 1500;

	typedef struct packed {
		logic [TOTAL_W-1:0] inversions;
		logic               overflow;
	} inv_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata = '0;   // [31:0] value
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [14:0] inversions, [15] zero
	logic                  m_axis_tuser;        // [0] overflow

	// Software copy of the run being counted
	logic signed [VALUE_BITS-1:0] run_vals [MAX_LEN];
	int                           run_fill = 0;
	int                           run_total = 0;
	logic                         run_dropped = 1'b0;

	inv_result_t pending_counts [$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_len = 0;
	int          hold_left = 0;

	inversion_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Count how many stored values exceed the new one; emit the total on last.
	task automatic count_inversions(input logic [DATA_W-1:0] data, input logic is_last);
		logic signed [VALUE_BITS-1:0] key;
		int                           greater;
		inv_result_t                  res;
		key = data[VALUE_BITS-1:0];
		if (run_fill < MAX_LEN) begin
			greater = 0;
			for (int i = 0; i < run_fill; i++)
				if (run_vals[i] > key)
					greater++;
			if (greater > SAT_TOTAL - run_total)
				run_total = SAT_TOTAL;
			else
				run_total += greater;
			run_vals[run_fill] = key;
			run_fill++;
		end else begin
			run_dropped = 1'b1;
		end
		if (is_last) begin
			res.inversions = run_total[TOTAL_W-1:0];
			res.overflow   = run_dropped;
			pending_counts.push_back(res);
			run_fill    = 0;
			run_total   = 0;
			run_dropped = 1'b0;
		end
	endtask

	// Predict on every input transfer, check every output transfer
	always @(posedge clk) begin
		inv_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				count_inversions(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_counts.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: inversions %0d overflow %0b",
							m_axis_tdata[TOTAL_W-1:0], m_axis_tuser);
				end else begin
					want = pending_counts.pop_front();
					if (m_axis_tdata[TOTAL_W-1:0] !== want.inversions ||
							m_axis_tuser !== want.overflow) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: inversions exp %0d got %0d, overflow exp %0b got %0b",
								want.inversions, m_axis_tdata[TOTAL_W-1:0],
								want.overflow, m_axis_tuser);
					end
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left == 0 && hold_len > 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stuck = 0;
			else
				stuck++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_value(input logic [DATA_W-1:0] value, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Pause the sender until every outstanding total has arrived
	task automatic wait_counts_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6: begin
				// narrow range, so equal values turn up often
				v = $urandom_range(0, 8);
				v = v - 32'd4;
			end
			7: begin
				case ($urandom_range(0, 3))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			8: begin
				if ($urandom_range(0, 1))
					v = 32'h8000_0000 + $urandom_range(0, 3);
				else
					v = 32'h7FFF_FFFF - $urandom_range(0, 3);
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic send_random_run(input int len);
		for (int i = 0; i < len; i++)
			send_value(pick_value(), i == len - 1);
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_value(32'h8000_0000, 1'b1);
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h8000_0000, 1'b1);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h7FFF_FFFF, 1'b1);
		// equal values are no inversion
		send_value(32'd7, 1'b0);
		send_value(32'd7, 1'b0);
		send_value(32'd7, 1'b1);
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'h0000_0001, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b1);
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h7FFF_FFFE, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'h8000_0001, 1'b0);
		send_value(32'h8000_0000, 1'b1);
		send_value(32'h5555_5555, 1'b0);
		send_value(32'hAAAA_AAAA, 1'b1);
		wait_counts_drained();
	endtask

	task automatic test_full_length();
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		// strictly falling run of full length gives the largest total
		for (int i = 0; i < MAX_LEN; i++)
			send_value(32'd1000 - i, i == MAX_LEN - 1);
		// one past capacity: the element marked last is itself dropped
		for (int i = 0; i <= MAX_LEN; i++)
			send_value(pick_value(), i == MAX_LEN);
		// well past capacity, several dropped elements before last
		send_random_run(MAX_LEN + 44);
		wait_counts_drained();
	endtask

	task automatic test_random_runs(input int n_items, input int idle_pct, input int stall_pct);
		int sent;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(17, 64);
			else
				len = $urandom_range(1, 16);
			send_random_run(len);
			sent += len;
		end
		wait_counts_drained();
	endtask

	task automatic test_backpressure();
		int sent;
		int len;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = HOLD_OFF;
		sent = 0;
		// keep offering short runs so totals pile up behind the held output
		while (sent < 400) begin
			len = ($urandom_range(0, 1)) ? 1 : $urandom_range(2, 6);
			send_random_run(len);
			sent += len;
		end
		wait_counts_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_length();
		test_random_runs(150, 0, 0);
		test_random_runs(150, 70, 0);
		test_random_runs(150, 0, 70);
		test_random_runs(150, 11, 11);
		test_backpressure();
		// let anything still in the row come out
		repeat (MAX_LEN + 50) @(posedge clk);
		if (errors == 0 && pending_counts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
hdl/ic_pkg.sv
hdl/ic_cell.sv
hdl/ic_tail.sv
hdl/inversion_counter.sv
hdl/ic_checker.sv
bench/inversion_counter_tb.sv
